[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/mrmc_pkg.sv]
// Types and constants shared by the media remote mode controller.
package mrmc_pkg;

    localparam logic [1:0] MD_ACTIVE   = 2'd0;
    localparam logic [1:0] MD_ASLEEP   = 2'd1;
    localparam logic [1:0] MD_CHARGING = 2'd2;

    localparam logic [1:0] CC_NONE = 2'd0;
    localparam logic [1:0] CC_DOWN = 2'd1;
    localparam logic [1:0] CC_UP   = 2'd2;

    localparam logic [15:0] KEY_VOL_UP     = 16'he900;
    localparam logic [15:0] KEY_VOL_DOWN   = 16'hea00;
    localparam logic [15:0] KEY_PREV       = 16'hb600;
    localparam logic [15:0] KEY_NEXT       = 16'hb500;
    localparam logic [15:0] KEY_PLAY       = 16'hcd00;
    localparam logic [15:0] KEY_MEDIA_STOP = 16'hb700;

    localparam logic [15:0] SLEEP_PLAYING_RESET = 16'd900;
    localparam logic [15:0] SLEEP_STOPPED_RESET = 16'd60;

    localparam logic [2:0] EVT_SECOND = 3'd0;
    localparam logic [2:0] EVT_BLINK  = 3'd1;
    localparam logic [2:0] EVT_FAST   = 3'd2;
    localparam logic [2:0] EVT_BUTTON = 3'd3;
    localparam logic [2:0] EVT_CHAR   = 3'd4;

    localparam logic [2:0] BTN_LEFT_CW   = 3'd0;
    localparam logic [2:0] BTN_LEFT_CCW  = 3'd1;
    localparam logic [2:0] BTN_RIGHT_PSH = 3'd2;
    localparam logic [2:0] BTN_RIGHT_CW  = 3'd3;
    localparam logic [2:0] BTN_RIGHT_CCW = 3'd4;

    localparam logic [7:0] CH_VBUS_ON  = 8'h31;
    localparam logic [7:0] CH_VBUS_OFF = 8'h30;
    localparam logic [7:0] CH_CC_UP    = 8'h75;
    localparam logic [7:0] CH_CC_DOWN  = 8'h64;
    localparam logic [7:0] CH_CC_NONE  = 8'h6e;
    localparam logic [7:0] CH_CHARGE   = 8'h63;
    localparam logic [7:0] CH_RUN      = 8'h68;

    localparam logic [2:0] REG_ADDR_PLAYING = 3'd0;

    typedef struct packed {
        logic [1:0]  mode;
        logic        playing;
        logic [15:0] countdown;
        logic [7:0]  blink;
    } mrmc_state_t;

    // Updates and keys caused by one event; key pairs are a code and a release.
    typedef struct packed {
        logic        led_v;
        logic        led;
        logic        cc_v;
        logic [1:0]  cc;
        logic        con_v;
        logic        con;
        logic        vb_v;
        logic        vb;
        logic [15:0] key_a;
        logic [15:0] key_b;
        logic [1:0]  pairs;
    } mrmc_pend_t;

endpackage

[hw/rtl/media_remote_mode_controller_unit.sv]
// Top level of the media remote mode controller: state, result buffer and register port.
//
//  channel | direction | carries
//  --------+-----------+-------------------------------------------------
//  s_      | in        | one event item (kind in tuser, button and char)
//  m_      | out       | one result per key code or release; one for updates alone
//  APB     | in/out    | the two sleep reload registers
//
// An event is decoded in the cycle it is accepted; its results (1, 2 or 4) leave
// the result buffer one per cycle while m_tready is high. An item that causes no
// result leaves the buffer empty and s_tready high. The next item is taken in the
// cycle the last result of the previous one is taken. Reset is synchronous and
// clears the state and the buffer; a stalled result holds until taken.
module media_remote_mode_controller_unit
    import mrmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // bits [2:0] button_code, [10:3] char_code, [15:11] zero
    input  logic [15:0] s_tdata,
    // bits [2:0] event_kind
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bits [0] key_valid, [16:1] key_code, [17] led_valid, [18] led_on,
    // [19] cc_valid, [21:20] cc_pull, [22] connect_valid, [23] connect_on,
    // [24] vbus_valid, [25] vbus_on, [27:26] mode_now, [31:28] zero
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] sleep_secs_playing_reg;
    logic [15:0] sleep_secs_stopped_reg;
    mrmc_state_t state_reg;
    mrmc_state_t state_next;
    mrmc_pend_t  pend_next;
    mrmc_pend_t  pend_reg;
    logic [1:0]  mode_out_reg;
    logic        busy_reg;
    logic [1:0]  idx_reg;
    logic [1:0]  last_idx_reg;
    logic [1:0]  last_idx_next;
    logic        in_take;
    logic        out_take;
    logic        out_last;
    logic        has_result;
    logic        upd_next;
    logic        cfg_write;
    logic        first_res;
    logic        key_valid;
    logic [15:0] key_code;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sleep_secs_playing_reg <= SLEEP_PLAYING_RESET;
            sleep_secs_stopped_reg <= SLEEP_STOPPED_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_ADDR_PLAYING[2]) begin
                sleep_secs_playing_reg <= pwdata[15:0];
            end else begin
                sleep_secs_stopped_reg <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_ADDR_PLAYING[2]) begin
            prdata = {16'd0, sleep_secs_playing_reg};
        end else begin
            prdata = {16'd0, sleep_secs_stopped_reg};
        end
    end

    mrmc_event u_event (
        .event_kind         (s_tuser),
        .button_code        (s_tdata[2:0]),
        .char_code          (s_tdata[10:3]),
        .sleep_secs_playing (sleep_secs_playing_reg),
        .sleep_secs_stopped (sleep_secs_stopped_reg),
        .state_cur          (state_reg),
        .state_new          (state_next),
        .pend               (pend_next)
    );

    assign out_last = (idx_reg == last_idx_reg);
    assign out_take = m_tvalid && m_tready;
    assign s_tready = !busy_reg || (out_take && out_last);
    assign in_take  = s_tvalid && s_tready;

    assign upd_next   = pend_next.led_v || pend_next.cc_v || pend_next.con_v
                        || pend_next.vb_v;
    assign has_result = (pend_next.pairs != 2'd0) || upd_next;

    always_comb begin
        case (pend_next.pairs)
            2'd2:    last_idx_next = 2'd3;
            2'd1:    last_idx_next = 2'd1;
            default: last_idx_next = 2'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            busy_reg  <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (in_take) begin
            state_reg <= state_next;
            busy_reg  <= has_result;
            idx_reg   <= 2'd0;
        end else if (out_take) begin
            if (out_last) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            pend_reg     <= pend_next;
            mode_out_reg <= state_next.mode;
            last_idx_reg <= last_idx_next;
        end
    end

    // Key codes sit in the even result slots; each odd slot is the release.
    always_comb begin
        case (idx_reg)
            2'd0:    key_code = pend_reg.key_a;
            2'd2:    key_code = pend_reg.key_b;
            default: key_code = 16'd0;
        endcase
    end

    assign key_valid = (pend_reg.pairs != 2'd0);
    assign first_res = (idx_reg == 2'd0);
    assign m_tvalid  = busy_reg;
    assign m_tlast   = out_last;

    assign m_tdata = {4'd0,
                      mode_out_reg,
                      first_res & pend_reg.vb,
                      first_res & pend_reg.vb_v,
                      first_res & pend_reg.con,
                      first_res & pend_reg.con_v,
                      pend_reg.cc & {2{first_res}},
                      first_res & pend_reg.cc_v,
                      first_res & pend_reg.led,
                      first_res & pend_reg.led_v,
                      key_code,
                      key_valid};

endmodule

[hw/rtl/mrmc_event.sv]
// Event decoder: next controller state and the updates and keys of one event.
module mrmc_event
    import mrmc_pkg::*;
(
    input  logic [2:0]  event_kind,
    input  logic [2:0]  button_code,
    input  logic [7:0]  char_code,
    input  logic [15:0] sleep_secs_playing,
    input  logic [15:0] sleep_secs_stopped,
    input  mrmc_state_t state_cur,
    output mrmc_state_t state_new,
    output mrmc_pend_t  pend
);

    always_comb begin
        state_new       = state_cur;
        state_new.blink = state_cur.blink + 8'd1;
        pend            = '0;

        unique case (event_kind)
            EVT_SECOND: begin
                if (state_cur.mode == MD_ASLEEP) begin
                    state_new.mode = MD_CHARGING;
                    pend.cc_v  = 1'b1;
                    pend.cc    = CC_UP;
                    pend.con_v = 1'b1;
                    pend.con   = 1'b0;
                    pend.vb_v  = 1'b1;
                    pend.vb    = 1'b1;
                end
                if (state_cur.countdown != 16'd0) begin
                    state_new.countdown = state_cur.countdown - 16'd1;
                    // Expiry sends stop and falls asleep without power commands.
                    if (state_cur.countdown == 16'd1) begin
                        pend.key_a     = KEY_MEDIA_STOP;
                        pend.pairs     = 2'd1;
                        state_new.mode = MD_ASLEEP;
                    end
                end
            end
            EVT_BLINK: begin
                if (state_cur.mode == MD_ACTIVE) begin
                    pend.led_v = 1'b1;
                    pend.led   = state_cur.playing ? state_new.blink[3] : 1'b1;
                end
                if (state_cur.mode == MD_CHARGING) begin
                    pend.led_v = 1'b1;
                    pend.led   = 1'b0;
                end
            end
            EVT_BUTTON: begin
                if (state_cur.mode == MD_CHARGING) begin
                    state_new.mode    = MD_ACTIVE;
                    state_new.playing = 1'b0;
                    pend.cc_v  = 1'b1;
                    pend.cc    = CC_DOWN;
                    pend.con_v = 1'b1;
                    pend.con   = 1'b1;
                    pend.vb_v  = 1'b1;
                    pend.vb    = 1'b0;
                end else begin
                    case (button_code)
                        BTN_LEFT_CW: begin
                            pend.key_a = KEY_VOL_UP;
                            pend.pairs = 2'd1;
                        end
                        BTN_LEFT_CCW: begin
                            pend.key_a = KEY_VOL_DOWN;
                            pend.pairs = 2'd1;
                        end
                        BTN_RIGHT_PSH: begin
                            state_new.playing = !state_cur.playing;
                            pend.key_a = KEY_MEDIA_STOP;
                            pend.pairs = 2'd1;
                            if (!state_cur.playing) begin
                                pend.key_b = KEY_PLAY;
                                pend.pairs = 2'd2;
                            end
                        end
                        BTN_RIGHT_CW: begin
                            if (state_cur.playing) begin
                                pend.key_a = KEY_NEXT;
                                pend.pairs = 2'd1;
                            end
                        end
                        BTN_RIGHT_CCW: begin
                            if (state_cur.playing) begin
                                pend.key_a = KEY_PREV;
                                pend.pairs = 2'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    state_new.countdown = state_new.playing ? sleep_secs_playing
                                                            : sleep_secs_stopped;
                end
            end
            EVT_CHAR: begin
                case (char_code)
                    CH_VBUS_ON: begin
                        pend.vb_v = 1'b1;
                        pend.vb   = 1'b1;
                    end
                    CH_VBUS_OFF: begin
                        pend.vb_v = 1'b1;
                        pend.vb   = 1'b0;
                    end
                    CH_CC_UP: begin
                        pend.cc_v = 1'b1;
                        pend.cc   = CC_UP;
                    end
                    CH_CC_DOWN: begin
                        pend.cc_v = 1'b1;
                        pend.cc   = CC_DOWN;
                    end
                    CH_CC_NONE: begin
                        pend.cc_v = 1'b1;
                        pend.cc   = CC_NONE;
                    end
                    CH_CHARGE: begin
                        state_new.mode = MD_CHARGING;
                        pend.cc_v  = 1'b1;
                        pend.cc    = CC_UP;
                        pend.con_v = 1'b1;
                        pend.con   = 1'b0;
                        pend.vb_v  = 1'b1;
                        pend.vb    = 1'b1;
                    end
                    CH_RUN: begin
                        state_new.mode    = MD_ACTIVE;
                        state_new.playing = 1'b0;
                        pend.cc_v  = 1'b1;
                        pend.cc    = CC_DOWN;
                        pend.con_v = 1'b1;
                        pend.con   = 1'b1;
                        pend.vb_v  = 1'b1;
                        pend.vb    = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                // The fast tick and unknown kinds only advance the blink counter.
            end
        endcase
    end

endmodule

[hw/rtl/mrmc_checker.sv]
// Port-level checker of the media remote mode controller and its bind.
`include "assert_macros.svh"

module mrmc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // A waiting result keeps its contents until it is taken.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // No new event is taken while results of the current one remain.
    `ASSERT_IMPLIES(a_no_take_mid_run, aclk, aresetn, m_tvalid && !m_tlast, !s_tready)

    // The results of one event follow each other without a gap.
    `ASSERT_NEXT(a_run_contiguous, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid)

    // A result without a key is the last result of its event.
    `ASSERT_IMPLIES(a_keyless_is_last, aclk, aresetn, m_tvalid && !m_tdata[0], m_tlast)

endmodule

bind media_remote_mode_controller_unit mrmc_checker u_mrmc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
